[src/vsa_pkg.sv]
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared widths, codes and types for the voice steal allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int NUM_VOICES_DEF = 32;
    localparam int ADDR_BITS_DEF  = 24;

    localparam int IN_ADDR_W = 24;
    localparam int VOICE_W   = 5;
    localparam int KIND_W    = 2;
    localparam int STATE_W   = 2;
    localparam int ATTEN_W   = 8;
    localparam int VOL_W     = 16;
    localparam int RULE_W    = 2;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 8;

    localparam logic [KIND_W-1:0] KIND_REC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

    localparam logic [STATE_W-1:0] VS_IDLE     = 2'd0;
    localparam logic [STATE_W-1:0] VS_PLAYING  = 2'd1;
    localparam logic [STATE_W-1:0] VS_RELEASED = 2'd2;
    localparam logic [STATE_W-1:0] VS_ENDED    = 2'd3;

    localparam logic [RULE_W-1:0] RULE_ENDED    = 2'd0;
    localparam logic [RULE_W-1:0] RULE_RELEASED = 2'd1;
    localparam logic [RULE_W-1:0] RULE_PLAYING  = 2'd2;
    localparam logic [RULE_W-1:0] RULE_DEFAULT  = 2'd3;

    typedef struct packed {
        logic                rd_en;
        logic                wb_en;
        logic [STATE_W-1:0]  wb_status;
        logic                done;
        logic [RULE_W-1:0]   rule;
        logic [VOICE_W-1:0]  chosen;
    } scan_out_t;

endpackage

[src/vsa_ram.sv]
// ----------------------------------------------------------------------------
// vsa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/vsa_scan.sv]
// ----------------------------------------------------------------------------
// vsa_scan
// Find engine: walks the voice table one entry per cycle, retires finished
// voices by write-back and tracks the ended / quietest / most attenuated picks.
// ----------------------------------------------------------------------------
module vsa_scan import vsa_pkg::*; #(
    parameter int NUM_VOICES = NUM_VOICES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 take,
    input  logic [STATE_W-1:0]   ent_status,
    input  logic                 ent_loops,
    input  logic [ADDR_BITS-1:0] ent_loop_begin,
    input  logic [ATTEN_W-1:0]   ent_atten,
    input  logic [VOL_W-1:0]     ent_volume,
    input  logic [ADDR_BITS-1:0] ent_address,
    output logic [IDX_W-1:0]     rd_addr,
    output logic [IDX_W-1:0]     wb_addr,
    output logic                 busy,
    output scan_out_t            ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

    logic [1:0]         state_reg, state_next;
    logic               issue_reg, issue_next;
    logic [IDX_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               chk_reg, chk_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               end_fnd_reg, end_fnd_next;
    logic [IDX_W-1:0]   end_idx_reg, end_idx_next;
    logic               rel_fnd_reg, rel_fnd_next;
    logic [IDX_W-1:0]   rel_idx_reg, rel_idx_next;
    logic [VOL_W-1:0]   rel_vol_reg, rel_vol_next;
    logic               ply_fnd_reg, ply_fnd_next;
    logic [IDX_W-1:0]   ply_idx_reg, ply_idx_next;
    logic [ATTEN_W-1:0] ply_att_reg, ply_att_next;

    logic               retire;
    logic [STATE_W-1:0] new_status;
    logic [ADDR_BITS-1:0] end_point;
    logic [IDX_W-1:0]   pick_idx;

    assign end_point = ent_loop_begin - ADDR_BITS'(1);

    always_comb
    begin
        retire = 1'b0;
        if (ent_status == VS_RELEASED && ent_volume == '0)
        begin
            retire = 1'b1;
        end
        else if (ent_status == VS_PLAYING && !ent_loops && ent_loop_begin != '0
                 && ent_address >= end_point)
        begin
            retire = 1'b1;
        end
        new_status = retire ? VS_ENDED : ent_status;
    end

    always_comb
    begin
        state_next   = state_reg;
        issue_next   = issue_reg;
        rd_cnt_next  = rd_cnt_reg;
        chk_next     = 1'b0;
        chk_idx_next = rd_cnt_reg;
        end_fnd_next = end_fnd_reg;
        end_idx_next = end_idx_reg;
        rel_fnd_next = rel_fnd_reg;
        rel_idx_next = rel_idx_reg;
        rel_vol_next = rel_vol_reg;
        ply_fnd_next = ply_fnd_reg;
        ply_idx_next = ply_idx_reg;
        ply_att_next = ply_att_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next   = S_SCAN;
                    issue_next   = 1'b1;
                    rd_cnt_next  = '0;
                    end_fnd_next = 1'b0;
                    rel_fnd_next = 1'b0;
                    ply_fnd_next = 1'b0;
                    ply_att_next = '0;
                end
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    chk_next = 1'b1;
                    if (rd_cnt_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + IDX_W'(1);
                    end
                end
                if (chk_reg)
                begin
                    if (new_status == VS_ENDED && !end_fnd_reg)
                    begin
                        end_fnd_next = 1'b1;
                        end_idx_next = chk_idx_reg;
                    end
                    if (new_status == VS_RELEASED &&
                        (!rel_fnd_reg || ent_volume < rel_vol_reg))
                    begin
                        rel_fnd_next = 1'b1;
                        rel_idx_next = chk_idx_reg;
                        rel_vol_next = ent_volume;
                    end
                    if (new_status == VS_PLAYING && ent_atten > ply_att_reg)
                    begin
                        ply_fnd_next = 1'b1;
                        ply_idx_next = chk_idx_reg;
                        ply_att_next = ent_atten;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issue_reg   <= 1'b0;
            chk_reg     <= 1'b0;
            end_fnd_reg <= 1'b0;
            rel_fnd_reg <= 1'b0;
            ply_fnd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            chk_reg     <= chk_next;
            end_fnd_reg <= end_fnd_next;
            rel_fnd_reg <= rel_fnd_next;
            ply_fnd_reg <= ply_fnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cnt_reg  <= rd_cnt_next;
        chk_idx_reg <= chk_idx_next;
        end_idx_reg <= end_idx_next;
        rel_idx_reg <= rel_idx_next;
        rel_vol_reg <= rel_vol_next;
        ply_idx_reg <= ply_idx_next;
        ply_att_reg <= ply_att_next;
    end

    always_comb
    begin
        if (end_fnd_reg)
        begin
            pick_idx = end_idx_reg;
            ctl.rule = RULE_ENDED;
        end
        else if (rel_fnd_reg)
        begin
            pick_idx = rel_idx_reg;
            ctl.rule = RULE_RELEASED;
        end
        else if (ply_fnd_reg)
        begin
            pick_idx = ply_idx_reg;
            ctl.rule = RULE_PLAYING;
        end
        else
        begin
            pick_idx = '0;
            ctl.rule = RULE_DEFAULT;
        end
        ctl.chosen    = VOICE_W'(pick_idx);
        ctl.rd_en     = (state_reg == S_SCAN) && issue_reg;
        ctl.wb_en     = (state_reg == S_SCAN) && chk_reg && retire;
        ctl.wb_status = VS_ENDED;
        ctl.done      = (state_reg == S_HOLD);
    end

    assign rd_addr = rd_cnt_reg;
    assign wb_addr = chk_idx_reg;
    assign busy    = (state_reg != S_IDLE);

endmodule

[src/voice_steal_allocator_unit.sv]
// ----------------------------------------------------------------------------
// voice_steal_allocator_unit
// Voice table with allocation by stealing: record/status writes and find.
//
//  channel  dir  tdata                           tuser
//  s_*      in   voice state looping loop_begin  kind
//                atten volume address
//  m_*      out  chosen_voice                    pick_rule
//
// A find walks every entry through the single read port of the record memory,
// one entry a cycle.
// Reset clears per-entry valid bits at once; no clearing pass.
// s_tready is low while a find runs or its result waits for the output reg.
// ----------------------------------------------------------------------------
module voice_steal_allocator_unit import vsa_pkg::*; #(
    parameter int NUM_VOICES = NUM_VOICES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [4:0] voice, [6:5] state_code, [7] looping, [31:8] loop_begin,
    // [39:32] atten_level, [55:40] current_volume, [79:56] current_address
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] chosen_voice, [7:5] zero
    output logic [M_DATA_W-1:0] m_tdata,
    // [1:0] pick_rule
    output logic [RULE_W-1:0]   m_tuser
);

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int REC_W = STATE_W + 1 + ADDR_BITS + ATTEN_W;
    localparam int STA_W = VOL_W + ADDR_BITS;

    logic [VOICE_W-1:0]   in_voice;
    logic [STATE_W-1:0]   in_state;
    logic                 in_loops;
    logic [IN_ADDR_W-1:0] in_loop_begin;
    logic [ATTEN_W-1:0]   in_atten;
    logic [VOL_W-1:0]     in_volume;
    logic [IN_ADDR_W-1:0] in_address;

    assign in_voice      = s_tdata[4:0];
    assign in_state      = s_tdata[6:5];
    assign in_loops      = s_tdata[7];
    assign in_loop_begin = s_tdata[31:8];
    assign in_atten      = s_tdata[39:32];
    assign in_volume     = s_tdata[55:40];
    assign in_address    = s_tdata[79:56];

    logic                 accept;
    logic                 in_range;
    logic                 wr_rec, wr_sta, start;
    logic [IDX_W-1:0]     wr_idx;

    logic                 busy;
    scan_out_t            ctl;
    logic [IDX_W-1:0]     rd_addr, wb_addr;
    logic                 take;

    logic                 rec_we;
    logic [IDX_W-1:0]     rec_waddr;
    logic [REC_W-1:0]     rec_wdata, rec_rdata, rec_eff;
    logic [STA_W-1:0]     sta_wdata, sta_rdata, sta_eff;

    logic [NUM_VOICES-1:0] rec_vld_reg, rec_vld_next;
    logic [NUM_VOICES-1:0] sta_vld_reg, sta_vld_next;
    logic                  rec_rv_reg, sta_rv_reg;

    logic [STATE_W-1:0]   ent_status;
    logic                 ent_loops;
    logic [ADDR_BITS-1:0] ent_loop_begin;
    logic [ATTEN_W-1:0]   ent_atten;
    logic [VOL_W-1:0]     ent_volume;
    logic [ADDR_BITS-1:0] ent_address;

    logic                 m_tvalid_reg;
    logic [VOICE_W-1:0]   chosen_reg;
    logic [RULE_W-1:0]    rule_reg;

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign in_range = (int'(in_voice) < NUM_VOICES);
    assign wr_idx   = IDX_W'(in_voice);

    always_comb
    begin
        wr_rec = 1'b0;
        wr_sta = 1'b0;
        start  = 1'b0;
        case (s_tuser)
            KIND_REC:  wr_rec = accept && in_range;
            KIND_STAT: wr_sta = accept && in_range;
            KIND_FIND: start  = accept;
            default:   start  = 1'b0;
        endcase
    end

    // retire write-back reuses the untouched fields of the entry just read
    assign rec_we    = wr_rec || ctl.wb_en;
    assign rec_waddr = ctl.wb_en ? wb_addr : wr_idx;
    assign rec_wdata = ctl.wb_en
        ? {ctl.wb_status, ent_loops, ent_loop_begin, ent_atten}
        : {in_state, in_loops, ADDR_BITS'(in_loop_begin), in_atten};
    assign sta_wdata = {in_volume, ADDR_BITS'(in_address)};

    vsa_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_VOICES)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_wdata),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rec_rdata)
    );

    vsa_ram #(
        .WIDTH (STA_W),
        .DEPTH (NUM_VOICES)
    ) u_sta_ram (
        .clk     (clk),
        .wr_en   (wr_sta),
        .wr_addr (wr_idx),
        .wr_data (sta_wdata),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (sta_rdata)
    );

    always_comb
    begin
        rec_vld_next = rec_vld_reg;
        sta_vld_next = sta_vld_reg;
        if (wr_rec)
        begin
            rec_vld_next[wr_idx] = 1'b1;
        end
        if (wr_sta)
        begin
            sta_vld_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_vld_reg <= '0;
            sta_vld_reg <= '0;
            rec_rv_reg  <= 1'b0;
            sta_rv_reg  <= 1'b0;
        end
        else
        begin
            rec_vld_reg <= rec_vld_next;
            sta_vld_reg <= sta_vld_next;
            if (ctl.rd_en)
            begin
                rec_rv_reg <= rec_vld_reg[rd_addr];
                sta_rv_reg <= sta_vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset value
    assign rec_eff = rec_rv_reg ? rec_rdata : '0;
    assign sta_eff = sta_rv_reg ? sta_rdata : '0;

    assign ent_status     = rec_eff[REC_W-1 -: STATE_W];
    assign ent_loops      = rec_eff[ADDR_BITS + ATTEN_W];
    assign ent_loop_begin = rec_eff[ATTEN_W +: ADDR_BITS];
    assign ent_atten      = rec_eff[ATTEN_W-1:0];
    assign ent_volume     = sta_eff[STA_W-1 -: VOL_W];
    assign ent_address    = sta_eff[ADDR_BITS-1:0];

    vsa_scan #(
        .NUM_VOICES (NUM_VOICES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .take           (take),
        .ent_status     (ent_status),
        .ent_loops      (ent_loops),
        .ent_loop_begin (ent_loop_begin),
        .ent_atten      (ent_atten),
        .ent_volume     (ent_volume),
        .ent_address    (ent_address),
        .rd_addr        (rd_addr),
        .wb_addr        (wb_addr),
        .busy           (busy),
        .ctl            (ctl)
    );

    assign take = ctl.done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chosen_reg <= ctl.chosen;
            rule_reg   <= ctl.rule;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(chosen_reg);
    assign m_tuser  = rule_reg;

endmodule

[src/vsa_checker.sv]
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks for the voice steal allocator.
// ----------------------------------------------------------------------------
module vsa_checker import vsa_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [KIND_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [RULE_W-1:0]   m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_FIND |=> !s_tready)
        else $error("find accepted without going busy");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != KIND_FIND |=> s_tready)
        else $error("write stalled the input");

    a_default_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == RULE_DEFAULT |-> m_tdata == '0)
        else $error("default pick not voice zero");

endmodule

bind voice_steal_allocator_unit vsa_checker u_vsa_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voice_steal_allocator_unit: drives record, status,
// find and unused words with random gaps and output stalls. A scoreboard keeps
// its own voice table and predicts the steal choice for every find.
// ----------------------------------------------------------------------------
module tb;
    import vsa_pkg::*;

    localparam int VOICES = NUM_VOICES_DEF;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int WORD_TARGET = 1900;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [RULE_W-1:0]  rule;
    } pick_t;

    class steal_scoreboard;
        logic [STATE_W-1:0]   slot_state      [VOICES];
        logic                 slot_loops      [VOICES];
        logic [IN_ADDR_W-1:0] slot_loop_start [VOICES];
        logic [ATTEN_W-1:0]   slot_atten      [VOICES];
        logic [VOL_W-1:0]     slot_volume     [VOICES];
        logic [IN_ADDR_W-1:0] slot_addr       [VOICES];
        pick_t                pending_picks[$];
        int                   mismatches;

        function new();
            for (int i = 0; i < VOICES; i++)
            begin
                slot_state[i]      = VS_IDLE;
                slot_loops[i]      = 1'b0;
                slot_loop_start[i] = '0;
                slot_atten[i]      = '0;
                slot_volume[i]     = '0;
                slot_addr[i]       = '0;
            end
            mismatches = 0;
        endfunction

        function pick_t steal_pick();
            pick_t              p;
            int                 best;
            logic [VOL_W-1:0]   quietest;
            logic [ATTEN_W-1:0] heaviest;
            for (int i = 0; i < VOICES; i++)
            begin
                if (slot_state[i] == VS_RELEASED && slot_volume[i] == '0)
                    slot_state[i] = VS_ENDED;
                else if (slot_state[i] == VS_PLAYING && !slot_loops[i] &&
                         slot_loop_start[i] != '0 &&
                         slot_addr[i] >= slot_loop_start[i] - 1)
                    slot_state[i] = VS_ENDED;
            end
            best = -1;
            p.rule = RULE_DEFAULT;
            for (int i = 0; i < VOICES && best < 0; i++)
            begin
                if (slot_state[i] == VS_ENDED)
                begin
                    best = i;
                    p.rule = RULE_ENDED;
                end
            end
            if (best < 0)
            begin
                quietest = '0;
                for (int i = 0; i < VOICES; i++)
                begin
                    if (slot_state[i] == VS_RELEASED && (best < 0 || slot_volume[i] < quietest))
                    begin
                        best = i;
                        quietest = slot_volume[i];
                        p.rule = RULE_RELEASED;
                    end
                end
            end
            if (best < 0)
            begin
                heaviest = '0;
                for (int i = 0; i < VOICES; i++)
                begin
                    if (slot_state[i] == VS_PLAYING && slot_atten[i] > heaviest)
                    begin
                        best = i;
                        heaviest = slot_atten[i];
                        p.rule = RULE_PLAYING;
                    end
                end
            end
            if (best < 0)
            begin
                best = 0;
                p.rule = RULE_DEFAULT;
            end
            p.voice = VOICE_W'(best);
            return p;
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
            int v;
            v = data[4:0];
            case (kind)
                KIND_REC:
                begin
                    slot_state[v]      = data[6:5];
                    slot_loops[v]      = data[7];
                    slot_loop_start[v] = data[31:8];
                    slot_atten[v]      = data[39:32];
                end
                KIND_STAT:
                begin
                    slot_volume[v] = data[55:40];
                    slot_addr[v]   = data[79:56];
                end
                KIND_FIND:
                    pending_picks.push_back(steal_pick());
                default: ;
            endcase
        endfunction

        function void flag(string what, pick_t want, pick_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected voice %0d rule %0d, got voice %0d rule %0d",
                         what, want.voice, want.rule, got.voice, got.rule);
        endfunction

        function void check_pick(logic [VOICE_W-1:0] voice, logic [RULE_W-1:0] rule);
            pick_t got;
            pick_t want;
            got.voice = voice;
            got.rule  = rule;
            if (pending_picks.size() == 0)
            begin
                flag("unexpected word", '0, got);
                return;
            end
            want = pending_picks.pop_front();
            if (want.voice != got.voice || want.rule != got.rule)
                flag("pick", want, got);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // voice, state, looping, loop_begin, atten, volume, address
    logic [KIND_W-1:0]   s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // chosen_voice, zero pad
    logic [RULE_W-1:0]   m_tuser;   // pick_rule

    steal_scoreboard sb;
    int  sent_words;
    int  quiet_cycles;
    bit  tx_rush;
    bit  rx_rush;

    voice_steal_allocator_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [S_DATA_W-1:0] pack_word(
        logic [VOICE_W-1:0] v, logic [STATE_W-1:0] st, logic lp, logic [IN_ADDR_W-1:0] lb,
        logic [ATTEN_W-1:0] at, logic [VOL_W-1:0] vol, logic [IN_ADDR_W-1:0] ad);
        return {ad, vol, at, lb, lp, st, v};
    endfunction

    function automatic logic [IN_ADDR_W-1:0] draw_addr();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return IN_ADDR_W'(1);
            default: return IN_ADDR_W'($urandom());
        endcase
    endfunction

    function automatic logic [ATTEN_W-1:0] draw_atten();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return ATTEN_W'($urandom());
        endcase
    endfunction

    // mix 0: idle/playing, 1: adds released, 2: any state
    function automatic logic [STATE_W-1:0] draw_state(int mix);
        case ($urandom_range(0, mix + 1))
            0:       return VS_IDLE;
            1:       return VS_PLAYING;
            2:       return VS_RELEASED;
            default: return VS_ENDED;
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] draw_volume(int mix);
        if (mix < 2)
            return ($urandom_range(0, 3) == 0) ? '1 : VOL_W'($urandom_range(1, 16'hFFFF));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return VOL_W'($urandom());
        endcase
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [S_DATA_W-1:0] data);
        int gap;
        gap = tx_rush ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        sent_words++;
    endtask

    task automatic send_rec(input int v, input logic [STATE_W-1:0] st, input logic lp,
                            input logic [IN_ADDR_W-1:0] lb, input logic [ATTEN_W-1:0] at);
        send_word(KIND_REC, pack_word(VOICE_W'(v), st, lp, lb, at, VOL_W'($urandom()),
                                      IN_ADDR_W'($urandom())));
    endtask

    task automatic send_stat(input int v, input logic [VOL_W-1:0] vol,
                             input logic [IN_ADDR_W-1:0] ad);
        send_word(KIND_STAT, pack_word(VOICE_W'(v), STATE_W'($urandom()), 1'($urandom()),
                                       IN_ADDR_W'($urandom()), ATTEN_W'($urandom()), vol, ad));
    endtask

    task automatic send_find();
        send_word(KIND_FIND, S_DATA_W'({$urandom(), $urandom(), $urandom()}));
    endtask

    task automatic drain_picks();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_picks.size() != 0) @(posedge clk);
    endtask

    task automatic random_word(input int mix, input int span);
        int                   v;
        int                   roll;
        logic [IN_ADDR_W-1:0] ad;
        v = $urandom_range(0, span - 1);
        roll = $urandom_range(0, 99);
        if (roll < 35)
            send_rec(v, draw_state(mix), (mix < 2) ? 1'b1 : 1'($urandom()),
                     draw_addr(), draw_atten());
        else if (roll < 65)
        begin
            ad = draw_addr();
            if (mix == 2 && $urandom_range(0, 1) == 1)
                ad = sb.slot_loop_start[v] + IN_ADDR_W'($urandom_range(0, 3))
                     - IN_ADDR_W'(2);
            send_stat(v, draw_volume(mix), ad);
        end
        else if (roll < 93)
            send_find();
        else
            send_word(KIND_NONE, S_DATA_W'({$urandom(), $urandom(), $urandom()}));
    endtask

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            stall = rx_rush ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_pick(m_tdata[VOICE_W-1:0], m_tuser);
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("voice_steal_allocator_unit verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int mix;
        int span;
        logic [STATE_W-1:0] st;
        sb = new();
        sent_words = 0;
        quiet_cycles = 0;
        tx_rush = 1'b0;
        rx_rush = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_REC;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unused kind, loop start zero, attenuation ties,
        // released at full volume, retire by address and by zero volume
        send_find();
        send_word(KIND_NONE, '1);
        send_rec(5, VS_PLAYING, 1'b0, '0, '0);
        send_stat(5, '0, '1);
        send_find();
        send_rec(31, VS_PLAYING, 1'b0, '1, '1);
        send_rec(7, VS_PLAYING, 1'b1, IN_ADDR_W'(1), '1);
        send_find();
        send_stat(10, '1, '0);
        send_rec(10, VS_RELEASED, 1'b1, '0, '0);
        send_stat(3, '1, '0);
        send_rec(3, VS_RELEASED, 1'b0, '0, '0);
        send_find();
        send_stat(31, '0, IN_ADDR_W'(24'hFFFFFE));
        send_find();
        send_rec(31, VS_IDLE, 1'b0, '0, '0);
        send_stat(20, '0, '0);
        send_rec(20, VS_RELEASED, 1'b0, '0, '0);
        send_find();
        send_rec(20, VS_IDLE, 1'b0, '0, '0);
        send_word(KIND_REC, pack_word('0, VS_ENDED, 1'b1, '1, '1, '1, '1));
        send_find();
        send_word(KIND_STAT, pack_word('1, VS_ENDED, 1'b1, '1, '1, '1, '1));
        send_rec(0, VS_IDLE, 1'b0, '0, '0);
        send_find();

        while (sent_words < WORD_TARGET)
        begin
            drain_picks();
            tx_rush = ($urandom_range(0, 3) == 0);
            rx_rush = ($urandom_range(0, 3) == 0);
            mix  = $urandom_range(0, 2);
            span = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 4) : VOICES;
            for (int v = 0; v < VOICES; v++)
            begin
                send_stat(v, draw_volume(mix), draw_addr());
                st = (v < span) ? draw_state(mix) : VS_IDLE;
                send_rec(v, st, (mix < 2) ? 1'b1 : 1'($urandom()), draw_addr(), draw_atten());
            end
            repeat (110) random_word(mix, span);
        end

        drain_picks();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_picks.size() == 0)
            $display("voice_steal_allocator_unit verification clean");
        else
            $display("voice_steal_allocator_unit verification failed");
        $finish;
    end
endmodule
